/* design/bilinear_texture_sampler_macros.svh */
// ----------------------------------------------------------------------------
// Bilinear texture sampler assertion macros
// Shared concurrent assertion forms for the sampler RTL.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_TEXTURE_SAMPLER_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition holds at every clock outside reset
`define BTS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`endif

/* design/bts_pkg.sv */
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Constants, codes and the item type passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

   localparam int MAX_TEXELS   = 65536;
   localparam int MAX_DIM      = 256;
   localparam int CHANNELS     = 3;
   localparam int CHANNEL_BITS = 16;

   localparam int ADDR_W  = $clog2(MAX_TEXELS);
   localparam int DIM_W   = 9;
   localparam int POS_W   = $clog2(MAX_DIM);
   localparam int FRAC_W  = 16;
   localparam int COORD_W = 32;
   localparam int SCALE_W = FRAC_W + POS_W;
   localparam int TEXEL_W = CHANNELS * CHANNEL_BITS;
   localparam int WGT_W   = FRAC_W + 2;
   localparam int ROW_W   = WGT_W + CHANNEL_BITS + 1;
   localparam int SUM_W   = WGT_W + ROW_W + 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = DIM_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1) + 1;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT = 1'b1;

   typedef struct packed {
      logic                sample;
      logic                invalid;
      logic [ADDR_W-1:0]   addr;
      logic                step_x;
      logic [DIM_W-1:0]    stride;
      logic [FRAC_W-1:0]   w1x;
      logic [FRAC_W-1:0]   w1y;
      logic [TEXEL_W-1:0]  texel;
   } bts_item_type;

endpackage

`default_nettype wire

/* design/bts_channels.sv */
// ----------------------------------------------------------------------------
// Bilinear texture sampler channels
// Valid/ready interfaces for the request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface bts_req_if;
   import bts_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [15:0]              texel_addr;
   logic signed [15:0]       in_ch0;
   logic signed [15:0]       in_ch1;
   logic signed [15:0]       in_ch2;
   logic signed [COORD_W-1:0] u_coord;
   logic signed [COORD_W-1:0] v_coord;
   logic                     flip_v;

   modport source (output valid, cmd, texel_addr, in_ch0, in_ch1, in_ch2,
                   u_coord, v_coord, flip_v, input ready);
   modport sink   (input valid, cmd, texel_addr, in_ch0, in_ch1, in_ch2,
                   u_coord, v_coord, flip_v, output ready);
endinterface

interface bts_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_ch0;
   logic signed [15:0] out_ch1;
   logic signed [15:0] out_ch2;
   logic               status;

   modport source (output valid, out_ch0, out_ch1, out_ch2, status, input ready);
   modport sink   (input valid, out_ch0, out_ch1, out_ch2, status, output ready);
endinterface

`default_nettype wire

/* design/bts_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

/* design/bts_front.sv */
// ----------------------------------------------------------------------------
// Sampler front end
// Accepts words, wraps and scales coordinates, forms base index and weights.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bilinear_texture_sampler_macros.svh"

module bts_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bts_req_if.sink                     req,
   input  wire logic [bts_pkg::DIM_W-1:0]  tex_width,
   input  wire logic [bts_pkg::DIM_W-1:0]  tex_height,
   input  wire logic [bts_pkg::QCNT_W-1:0] queue_count,
   output logic                        push,
   output bts_pkg::bts_item_type       push_item
);
   import bts_pkg::*;

   logic [DIM_W-1:0]   w_eff, h_eff;
   logic [POS_W-1:0]   wm1, hm1;
   logic [FRAC_W-1:0]  fu, fv;
   logic               accept;
   logic [QCNT_W-1:0]  credit;

   logic               a_valid_ff, a_valid_in;
   logic               a_sample_ff, a_invalid_ff, a_single_ff;
   logic [ADDR_W-1:0]  a_addr_ff;
   logic [TEXEL_W-1:0] a_texel_ff;
   logic [SCALE_W-1:0] a_su_ff, a_sv_ff;
   logic [DIM_W-1:0]   a_w_ff, a_h_ff;

   logic [POS_W-1:0]   px, py, xlim, ylim;
   logic [DIM_W-1:0]   wlim, hlim;
   logic [POS_W+DIM_W-1:0] base;

   logic               b_valid_ff;
   bts_item_type       b_item_ff, b_item_in;

   assign w_eff = (tex_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : tex_width;
   assign h_eff = (tex_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : tex_height;
   assign wm1   = POS_W'(w_eff - DIM_W'(1));
   assign hm1   = POS_W'(h_eff - DIM_W'(1));

   assign credit    = queue_count + QCNT_W'(a_valid_ff) + QCNT_W'(b_valid_ff);
   assign req.ready = credit < QCNT_W'(QUEUE_DEPTH);
   assign accept    = req.valid && req.ready;
   assign a_valid_in = accept;

   assign fu = req.u_coord[FRAC_W-1:0];
   assign fv = req.flip_v ? FRAC_W'(0) - req.v_coord[FRAC_W-1:0]
                          : req.v_coord[FRAC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_sample_ff  <= req.cmd == CMD_SAMPLE;
      a_single_ff  <= (w_eff == DIM_W'(1)) && (h_eff == DIM_W'(1));
      a_invalid_ff <= !((w_eff == DIM_W'(1)) && (h_eff == DIM_W'(1)))
                      && ((w_eff < DIM_W'(2)) || (h_eff < DIM_W'(2)));
      a_addr_ff    <= req.texel_addr[ADDR_W-1:0];
      a_texel_ff   <= {req.in_ch2, req.in_ch1, req.in_ch0};
      a_su_ff      <= SCALE_W'(fu) * SCALE_W'(wm1);
      a_sv_ff      <= SCALE_W'(fv) * SCALE_W'(hm1);
      a_w_ff       <= w_eff;
      a_h_ff       <= h_eff;
   end

   assign wlim = a_w_ff - DIM_W'(2);
   assign hlim = a_h_ff - DIM_W'(2);
   assign xlim = wlim[POS_W-1:0];
   assign ylim = hlim[POS_W-1:0];
   assign px = (a_su_ff[SCALE_W-1:FRAC_W] > xlim) ? xlim : a_su_ff[SCALE_W-1:FRAC_W];
   assign py = (a_sv_ff[SCALE_W-1:FRAC_W] > ylim) ? ylim : a_sv_ff[SCALE_W-1:FRAC_W];
   assign base = (POS_W+DIM_W)'(py) * (POS_W+DIM_W)'(a_w_ff) + (POS_W+DIM_W)'(px);

   always_comb begin
      b_item_in         = '0;
      b_item_in.sample  = a_sample_ff;
      b_item_in.invalid = a_invalid_ff;
      b_item_in.texel   = a_texel_ff;
      if (a_sample_ff) begin
         b_item_in.addr = a_single_ff ? '0 : base[ADDR_W-1:0];
      end else begin
         b_item_in.addr = a_addr_ff;
      end
      b_item_in.step_x = !a_single_ff;
      b_item_in.stride = a_single_ff ? '0 : a_w_ff;
      b_item_in.w1x    = a_single_ff ? '0 : a_su_ff[FRAC_W-1:0];
      b_item_in.w1y    = a_single_ff ? '0 : a_sv_ff[FRAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      b_item_ff <= b_item_in;
   end

   assign push      = b_valid_ff;
   assign push_item = b_item_ff;

   `BTS_ASSERT_ALWAYS(a_credit_bound, clock, reset, credit <= QCNT_W'(QUEUE_DEPTH))
   `BTS_ASSERT_IMPLY(a_no_accept_full, clock, reset,
      queue_count == QCNT_W'(QUEUE_DEPTH), !req.ready)

endmodule

`default_nettype wire

/* design/bts_queue.sv */
// ----------------------------------------------------------------------------
// Sampler item queue
// Short FIFO between the front end and the texel back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bilinear_texture_sampler_macros.svh"

module bts_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire bts_pkg::bts_item_type  push_item,
   input  wire logic                   pop,
   output logic                        head_valid,
   output bts_pkg::bts_item_type       head_item,
   output logic [bts_pkg::QCNT_W-1:0]  count
);
   import bts_pkg::*;

   bts_item_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_item  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   `BTS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `BTS_ASSERT_IMPLY(a_pop_nonempty, clock, reset, pop, count_ff != '0)
   `BTS_ASSERT_IMPLY(a_push_room, clock, reset, push, count_ff != QCNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

/* design/bts_back.sv */
// ----------------------------------------------------------------------------
// Sampler back end
// Texel store, four neighbor reads, bilinear blend and response register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bilinear_texture_sampler_macros.svh"

module bts_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire bts_pkg::bts_item_type  head_item,
   output logic                        pop,
   bts_rsp_if.source                   rsp
);
   import bts_pkg::*;

   logic                adv;
   logic                wr_en;
   logic [ADDR_W-1:0]   rd_addr [4];
   logic [TEXEL_W-1:0]  rd_data [4];

   logic                s1_valid_ff, s1_invalid_ff;
   logic [FRAC_W-1:0]   s1_w1x_ff, s1_w1y_ff;

   logic signed [WGT_W-1:0] w0x, w1x, w0y, w1y;
   logic signed [ROW_W-1:0] r0_in [CHANNELS];
   logic signed [ROW_W-1:0] r1_in [CHANNELS];
   logic signed [ROW_W-1:0] r0_ff [CHANNELS];
   logic signed [ROW_W-1:0] r1_ff [CHANNELS];
   logic                s2_valid_ff, s2_invalid_ff;
   logic [FRAC_W-1:0]   s2_w1y_ff;

   logic signed [SUM_W-1:0] sum_in [CHANNELS];
   logic signed [SUM_W-1:0] sum_ff [CHANNELS];
   logic                s3_valid_ff, s3_invalid_ff;

   logic [SUM_W-1:0]        biased [CHANNELS];
   logic [CHANNEL_BITS-1:0] rounded [CHANNELS];
   logic                    out_valid_ff;
   logic                    out_status_ff;
   logic [CHANNEL_BITS-1:0] out_ch_ff [CHANNELS];

   assign adv   = !out_valid_ff || rsp.ready;
   assign pop   = head_valid && adv;
   assign wr_en = pop && !head_item.sample;

   assign rd_addr[0] = head_item.addr;
   assign rd_addr[1] = head_item.addr + ADDR_W'(head_item.step_x);
   assign rd_addr[2] = head_item.addr + ADDR_W'(head_item.stride);
   assign rd_addr[3] = head_item.addr + ADDR_W'(head_item.stride)
                       + ADDR_W'(head_item.step_x);

   for (genvar k = 0; k < 4; k++) begin : g_bank
      bts_ram #(.WIDTH(TEXEL_W), .DEPTH(MAX_TEXELS)) u_ram (
         .clock (clock),
         .we    (wr_en),
         .waddr (head_item.addr),
         .wdata (head_item.texel),
         .re    (adv),
         .raddr (rd_addr[k]),
         .rdata (rd_data[k])
      );
   end

   assign w1x = $signed({2'b00, s1_w1x_ff});
   assign w0x = $signed(WGT_W'(1 << FRAC_W)) - w1x;
   assign w1y = $signed({2'b00, s2_w1y_ff});
   assign w0y = $signed(WGT_W'(1 << FRAC_W)) - w1y;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      logic signed [CHANNEL_BITS-1:0] v00, v10, v01, v11;
      assign v00 = rd_data[0][c*CHANNEL_BITS +: CHANNEL_BITS];
      assign v10 = rd_data[1][c*CHANNEL_BITS +: CHANNEL_BITS];
      assign v01 = rd_data[2][c*CHANNEL_BITS +: CHANNEL_BITS];
      assign v11 = rd_data[3][c*CHANNEL_BITS +: CHANNEL_BITS];
      assign r0_in[c] = ROW_W'(w0x) * ROW_W'(v00) + ROW_W'(w1x) * ROW_W'(v10);
      assign r1_in[c] = ROW_W'(w0x) * ROW_W'(v01) + ROW_W'(w1x) * ROW_W'(v11);
      assign sum_in[c] = SUM_W'(w0y) * SUM_W'(r0_ff[c])
                         + SUM_W'(w1y) * SUM_W'(r1_ff[c]);
      assign biased[c] = sum_ff[c] + SUM_W'(64'd1 << (2 * FRAC_W - 1));
      assign rounded[c] = biased[c][2*FRAC_W +: CHANNEL_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= pop && head_item.sample;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_invalid_ff <= head_item.invalid;
         s1_w1x_ff     <= head_item.w1x;
         s1_w1y_ff     <= head_item.w1y;
         s2_invalid_ff <= s1_invalid_ff;
         s2_w1y_ff     <= s1_w1y_ff;
         s3_invalid_ff <= s2_invalid_ff;
         out_status_ff <= s3_invalid_ff;
         for (int c = 0; c < CHANNELS; c++) begin
            r0_ff[c]     <= r0_in[c];
            r1_ff[c]     <= r1_in[c];
            sum_ff[c]    <= sum_in[c];
            out_ch_ff[c] <= s3_invalid_ff ? '0 : rounded[c];
         end
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.status  = out_status_ff;
   assign rsp.out_ch0 = out_ch_ff[0];
   assign rsp.out_ch1 = out_ch_ff[1];
   assign rsp.out_ch2 = out_ch_ff[2];

   `BTS_ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp.valid && rsp.status,
      rsp.out_ch0 == '0 && rsp.out_ch1 == '0 && rsp.out_ch2 == '0)
   `BTS_ASSERT_IMPLY(a_no_write_stalled, clock, reset, wr_en, adv)

endmodule

`default_nettype wire

/* design/bilinear_texture_sampler.sv */
// ----------------------------------------------------------------------------
// Bilinear texture sampler
// Repeat-wrapped bilinear sampling of a three-channel fixed-point texture.
// ----------------------------------------------------------------------------
// Takes one request word per cycle while req.ready is high. A write word
// stores a texel at its row-major address and returns nothing; a sample
// word returns one response: two front stages form the base index and
// Q0.16 weights, a four-entry queue decouples them from the back end, where
// four replicated texel memories read the neighbors together into registered
// read data, and two multiply stages plus the response register blend them.
// Sustained rate is one word per cycle unless the response side stalls.
// Set tex_width and tex_height only while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_texture_sampler (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bts_req_if.sink                            req,
   bts_rsp_if.source                          rsp,
   input  wire logic                          csr_we,
   input  wire logic [bts_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bts_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bts_pkg::*;

   logic [DIM_W-1:0]  tex_width_ff, tex_height_ff;
   logic              push, pop, head_valid;
   bts_item_type      push_item, head_item;
   logic [QCNT_W-1:0] queue_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= DIM_W'(1);
         tex_height_ff <= DIM_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_TEX_WIDTH:  tex_width_ff  <= csr_wdata;
            CSR_TEX_HEIGHT: tex_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   bts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .tex_width   (tex_width_ff),
      .tex_height  (tex_height_ff),
      .queue_count (queue_count),
      .push        (push),
      .push_item   (push_item)
   );

   bts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .count      (queue_count)
   );

   bts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire
